// ----- src/clook_pkg.sv -----
// Shared types and constants of the C-LOOK disk scheduler.
package clook_pkg;

	localparam int CYL_W      = 16;
	localparam int SEEK_W     = 22;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 40;

	localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_RUN  = 1'b1
	} command_t;

	typedef struct packed {
		logic load;
		logic run_init;
		logic scan_init;
		logic scan_step;
		logic calc;
		logic emit;
		logic emit_empty;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic run_last;
		logic out_free;
	} dp_status_t;

endpackage

// ----- src/clook_disk_scheduler.sv -----
// Top level of the C-LOOK disk scheduler.
//
// Requests enter on the s_ channel. s_tuser is the command: load appends
// s_tdata[15:0] as a request cylinder (dropped once DEPTH requests are held);
// run takes s_tdata[31:16] as the start head and serves every held request in
// C-LOOK order: upward from the first request at or above the head, then a
// free jump to the lowest request and upward through the rest.
// Each served request leaves on the m_ channel with its cylinder and running
// seek total (saturating); m_tlast marks the final one of a run. A run with
// nothing held gives one result with m_tuser (none pending) set.
// With n held requests, each result comes from one scan of the store through
// its single read port, then a drain and a calc step before the emit; a run
// repeats this for every held request. An empty run emits its one result directly.
// Requests stay held after a run and are served again by the next one.
// Reset clears the request count and the output valid flag; store contents
// are not cleared, since only entries below the count are ever read.
// When the receiver stalls, the output register holds its result while the
// scan for the next one goes on; the block then waits before loading it.
module clook_disk_scheduler #(
	parameter int DEPTH    = 32,
	parameter int CYL_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [clook_pkg::IN_DATA_W-1:0]      s_tdata,  // cylinder, start_head
	input  logic                                 s_tuser,  // command
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [clook_pkg::OUT_DATA_W-1:0]     m_tdata,  // served_cylinder, seek_total
	output logic                                 m_tuser,  // none_pending
	output logic                                 m_tlast   // last_served
);
	import clook_pkg::*;

	dp_cmd_t            cmd;
	dp_status_t         status;
	logic [CYL_W-1:0]   served_cylinder;
	logic [SEEK_W-1:0]  seek_total;

	// Sequence loads, scans and emits.
	clook_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (command_t'(s_tuser)),
		.s_tready (s_tready),
		.cmd      (cmd),
		.status   (status)
	);

	// Hold the store, pick the next request in order, advance the seek sum.
	clook_dp #(
		.DEPTH    (DEPTH),
		.CYL_BITS (CYL_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cylinder        (s_tdata[CYL_W-1:0]),
		.start_head      (s_tdata[2*CYL_W-1:CYL_W]),
		.served_cylinder (served_cylinder),
		.seek_total      (seek_total),
		.none_pending    (m_tuser),
		.last_served     (m_tlast),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready)
	);

	// Pack the result, padding to whole bytes.
	assign m_tdata = {(OUT_DATA_W - CYL_W - SEEK_W)'(0), seek_total, served_cylinder};

endmodule

// ----- src/clook_ram.sv -----
// Generic simple dual-port RAM with registered read.
module clook_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/clook_ctrl.sv -----
// Controller state machine of the C-LOOK disk scheduler.
module clook_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  clook_pkg::command_t    command,
	output logic                   s_tready,
	output clook_pkg::dp_cmd_t     cmd,
	input  clook_pkg::dp_status_t  status
);
	import clook_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_CALC,
		ST_EMIT,
		ST_EMPTY
	} state_t;

	state_t state_q;

	always_comb begin
		cmd      = '0;
		s_tready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (command == CMD_LOAD) begin
						cmd.load = 1'b1;
					end else if (!status.count_zero) begin
						cmd.run_init  = 1'b1;
						cmd.scan_init = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.emit      = 1'b1;
					cmd.scan_init = !status.run_last;
				end
			end
			ST_EMPTY: begin
				cmd.emit_empty = status.out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && command == CMD_RUN) begin
						state_q <= status.count_zero ? ST_EMPTY : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (status.scan_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) begin
						state_q <= status.run_last ? ST_IDLE : ST_SCAN;
					end
				end
				ST_EMPTY: begin
					if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- src/clook_dp.sv -----
// Datapath of the C-LOOK disk scheduler: request store, selection scan, seek sum, output register.
module clook_dp #(
	parameter int DEPTH    = 32,
	parameter int CYL_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  clook_pkg::dp_cmd_t                  cmd,
	output clook_pkg::dp_status_t               status,
	input  logic [clook_pkg::CYL_W-1:0]         cylinder,
	input  logic [clook_pkg::CYL_W-1:0]         start_head,
	output logic [clook_pkg::CYL_W-1:0]         served_cylinder,
	output logic [clook_pkg::SEEK_W-1:0]        seek_total,
	output logic                                none_pending,
	output logic                                last_served,
	output logic                                out_valid,
	input  logic                                out_ready
);
	import clook_pkg::*;

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = 1 + CYL_W + IW;

	logic [CW-1:0]     count_q;
	logic [IW-1:0]     addr_q;
	logic              rd_pend_s1;
	logic [IW-1:0]     idx_s1;
	logic [CYL_W-1:0]  start_q;
	logic [CYL_W-1:0]  head_q;
	logic [SEEK_W-1:0] acc_q;
	logic [CW-1:0]     served_q;
	logic [KW-1:0]     prev_key_q;
	logic              prev_valid_q;
	logic              prev_low_q;
	logic [KW-1:0]     best_key_q;
	logic              best_valid_q;
	logic [CYL_W-1:0]  dist_q;
	logic              out_valid_q;

	logic [CYL_BITS-1:0] rdata;
	logic [CYL_W-1:0]    rd_val;
	logic [KW-1:0]       cand_key;
	logic                take;
	logic                store_we;
	logic                best_low;
	logic [CYL_W-1:0]    best_val;
	logic [SEEK_W:0]     seek_sum;
	logic [SEEK_W-1:0]   seek_next;

	clook_ram #(
		.WIDTH (CYL_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (count_q[IW-1:0]),
		.wdata (CYL_BITS'(cylinder)),
		.re    (cmd.scan_step),
		.raddr (addr_q),
		.rdata (rdata)
	);

	assign store_we = cmd.load && (count_q < CW'(DEPTH));

	// Order key: requests below the start head go after the upward sweep;
	// the index breaks ties between equal cylinders.
	assign rd_val   = CYL_W'(rdata);
	assign cand_key = {rd_val < start_q, rd_val, idx_s1};
	assign take     = rd_pend_s1
		&& (!prev_valid_q || cand_key > prev_key_q)
		&& (!best_valid_q || cand_key < best_key_q);

	assign best_low = best_key_q[KW-1];
	assign best_val = best_key_q[IW +: CYL_W];

	assign seek_sum  = {1'b0, acc_q} + (SEEK_W + 1)'(dist_q);
	assign seek_next = (seek_sum > {1'b0, SEEK_MAX}) ? SEEK_MAX : seek_sum[SEEK_W-1:0];

	assign status.count_zero = (count_q == '0);
	assign status.scan_last  = (CW'(addr_q) == count_q - CW'(1));
	assign status.run_last   = (served_q + CW'(1) == count_q);
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			addr_q       <= '0;
			rd_pend_s1   <= 1'b0;
			served_q     <= '0;
			prev_valid_q <= 1'b0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (store_we) begin
				count_q <= count_q + CW'(1);
			end
			rd_pend_s1 <= cmd.scan_step;
			if (cmd.scan_init) begin
				addr_q       <= '0;
				best_valid_q <= 1'b0;
			end else if (cmd.scan_step) begin
				addr_q <= addr_q + IW'(1);
			end
			if (take) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.run_init) begin
				served_q     <= '0;
				prev_valid_q <= 1'b0;
			end else if (cmd.emit) begin
				served_q     <= served_q + CW'(1);
				prev_valid_q <= 1'b1;
			end
			if (cmd.emit || cmd.emit_empty) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		if (take) begin
			best_key_q <= cand_key;
		end
		if (cmd.run_init) begin
			start_q    <= start_head;
			head_q     <= start_head;
			acc_q      <= '0;
			prev_low_q <= 1'b0;
		end else if (cmd.emit) begin
			head_q     <= best_val;
			acc_q      <= seek_next;
			prev_low_q <= best_low;
			prev_key_q <= best_key_q;
		end
		// The jump back to the lowest request adds no distance.
		if (cmd.calc) begin
			if (best_low && !prev_low_q) begin
				dist_q <= '0;
			end else if (best_val >= head_q) begin
				dist_q <= best_val - head_q;
			end else begin
				dist_q <= head_q - best_val;
			end
		end
		if (cmd.emit) begin
			served_cylinder <= best_val;
			seek_total      <= seek_next;
			none_pending    <= 1'b0;
			last_served     <= status.run_last;
		end else if (cmd.emit_empty) begin
			served_cylinder <= '0;
			seek_total      <= '0;
			none_pending    <= 1'b1;
			last_served     <= 1'b1;
		end
	end

`ifndef SYNTHESIS
	a_emit_has_pick: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> best_valid_q)
		else $error("emit without a selected request");
	a_emit_ascends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && prev_valid_q) |-> (best_key_q > prev_key_q))
		else $error("service order key did not advance");
	a_served_bound: assert property (@(posedge clk) disable iff (!arst_n)
		served_q <= count_q)
		else $error("more requests served than loaded");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("request count beyond store depth");
`endif

endmodule

// ----- bench/tb_clook_disk_scheduler.sv -----
// Self-checking bench for the C-LOOK disk scheduler: random request stream, scoreboard on results.
module tb_clook_disk_scheduler;
	import clook_pkg::*;

	localparam int STORE_DEPTH  = 32;
	localparam int RANDOM_ITEMS = 500;
	localparam int CYCLE_LIMIT  = 4000000;
	// Let a trailing load settle before the final verdict.
	localparam int SETTLE_CYCLES = 64;
	// No idling on either side inside this window of cycles.
	localparam int QUIET_FROM = 30000;
	localparam int QUIET_TO   = 80000;

	// One request as the sender sees it.
	typedef struct {
		command_t          cmd;
		logic [CYL_W-1:0]  cyl;
		logic [CYL_W-1:0]  head;
	} disk_req_t;

	// One served cylinder as the scheduler should report it.
	typedef struct {
		logic [CYL_W-1:0]  cyl;
		logic [SEEK_W-1:0] seek;
		logic              none;
		logic              last;
	} service_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // cylinder, start_head
	logic                  s_tuser = 1'b0; // command
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // served_cylinder, seek_total
	logic                  m_tuser;        // none_pending
	logic                  m_tlast;        // last_served

	disk_req_t request_queue[$];
	service_t  expected_service[$];

	// Shadow of the scheduler's request store and count.
	logic [CYL_W-1:0] held_cyl[STORE_DEPTH];
	int               held_n = 0;

	disk_req_t cur_req;
	service_t  want_svc;
	int        cycle_count = 0;
	int        error_count = 0;

	clook_disk_scheduler #(
		.DEPTH(STORE_DEPTH),
		.CYL_BITS(CYL_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Idle with a chance of about 28 in a hundred, except inside the quiet window.
	function automatic bit idle_now();
		if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
			return 1'b0;
		return $urandom_range(99) < 28;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
			cycle_count);
		error_count++;
	endtask

	// Sort the held requests, then serve them C-LOOK style from the given head:
	// upward from the first request at or above it, free jump to the lowest
	// request, upward through the rest. An empty store yields one none-pending result.
	task automatic predict_clook_run(input logic [CYL_W-1:0] head);
		logic [CYL_W-1:0] key;
		logic [CYL_W-1:0] pos;
		int               b;
		int               first;
		int               k;
		int               gap;
		int               seek;
		service_t         svc;
		if (held_n == 0) begin
			svc.cyl  = '0;
			svc.seek = '0;
			svc.none = 1'b1;
			svc.last = 1'b1;
			expected_service.push_back(svc);
			return;
		end
		for (int a = 1; a < held_n; a++) begin
			key = held_cyl[a];
			b = a;
			while (b > 0 && held_cyl[b-1] > key) begin
				held_cyl[b] = held_cyl[b-1];
				b--;
			end
			held_cyl[b] = key;
		end
		first = held_n;
		for (int i = held_n - 1; i >= 0; i--)
			if (held_cyl[i] >= head)
				first = i;
		pos  = head;
		seek = 0;
		for (int j = 0; j < held_n; j++) begin
			// The wrap to the lowest request costs no seek; when every request
			// lies below the head this happens before the first service.
			if (j == held_n - first)
				pos = held_cyl[0];
			k = (first + j) % held_n;
			gap = (held_cyl[k] >= pos) ? int'(held_cyl[k]) - int'(pos)
				: int'(pos) - int'(held_cyl[k]);
			seek += gap;
			if (seek > int'(SEEK_MAX))
				seek = int'(SEEK_MAX);
			pos = held_cyl[k];
			svc.cyl  = held_cyl[k];
			svc.seek = seek[SEEK_W-1:0];
			svc.none = 1'b0;
			svc.last = (j == held_n - 1);
			expected_service.push_back(svc);
		end
	endtask

	// Driver: predict on each accepted request, then present the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (cur_req.cmd == CMD_RUN) begin
					predict_clook_run(cur_req.head);
				end else if (held_n < STORE_DEPTH) begin
					// Drop loads once the store is full.
					held_cyl[held_n] = cur_req.cyl;
					held_n++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (request_queue.size() != 0 && !idle_now()) begin
					cur_req = request_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_req.head, cur_req.cyl};
					s_tuser  <= cur_req.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_service.size() == 0) begin
					report_mismatch("unexpected result, cylinder", 32'(m_tdata[CYL_W-1:0]), '0);
				end else begin
					want_svc = expected_service.pop_front();
					if (m_tdata[CYL_W-1:0] !== want_svc.cyl)
						report_mismatch("served_cylinder", 32'(m_tdata[CYL_W-1:0]),
							32'(want_svc.cyl));
					if (m_tdata[CYL_W+SEEK_W-1:CYL_W] !== want_svc.seek)
						report_mismatch("seek_total", 32'(m_tdata[CYL_W+SEEK_W-1:CYL_W]),
							32'(want_svc.seek));
					if (m_tuser !== want_svc.none)
						report_mismatch("none_pending", 32'(m_tuser), 32'(want_svc.none));
					if (m_tlast !== want_svc.last)
						report_mismatch("last_served", 32'(m_tlast), 32'(want_svc.last));
				end
			end
			m_tready <= !idle_now();
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic push_req(input command_t cmd, input logic [CYL_W-1:0] cyl,
			input logic [CYL_W-1:0] head);
		disk_req_t r;
		r.cmd  = cmd;
		r.cyl  = cyl;
		r.head = head;
		request_queue.push_back(r);
	endtask

	// Pick a cylinder value biased toward the extremes and tight clusters.
	function automatic logic [CYL_W-1:0] pick_cyl();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return CYL_W'($urandom_range(63));
			default: return CYL_W'($urandom);
		endcase
	endfunction

	initial begin
		logic [CYL_W-1:0] loaded[$];
		logic [CYL_W-1:0] v;
		int               gen_held;
		int               counted;

		// Directed: empty run first, then extremes, duplicates and head placement.
		push_req(CMD_RUN, 16'h0000, 16'h1234);
		push_req(CMD_LOAD, 16'h0000, 16'hFFFF);
		push_req(CMD_LOAD, 16'h7FFF, 16'h0000);
		push_req(CMD_LOAD, 16'h8000, 16'h0000);
		push_req(CMD_LOAD, 16'h8000, 16'h0000);
		push_req(CMD_LOAD, 16'h5555, 16'h0000);
		push_req(CMD_LOAD, 16'hAAAA, 16'h0000);
		// Head above every request: wrap at once.
		push_req(CMD_RUN, 16'hFFFF, 16'hFFFF);
		// Head at zero: straight upward sweep.
		push_req(CMD_RUN, 16'h0000, 16'h0000);
		// Head equal to a duplicated request.
		push_req(CMD_RUN, 16'hFFFF, 16'h8000);
		push_req(CMD_RUN, 16'h1234, 16'h9000);
		push_req(CMD_LOAD, 16'hFFFF, 16'h5A5A);
		// Head equal to the highest request: serve it, then wrap.
		push_req(CMD_RUN, 16'h0000, 16'hFFFF);
		push_req(CMD_RUN, 16'hFFFF, 16'h0001);
		loaded = '{16'h0000, 16'h7FFF, 16'h8000, 16'h8000, 16'h5555, 16'hAAAA, 16'hFFFF};
		gen_held = 7;

		// Random: loads fill the store, runs with random content follow; loads
		// past a full store act as noise.
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			if ($urandom_range(99) < (gen_held < STORE_DEPTH ? 60 : 20)) begin
				v = pick_cyl();
				push_req(CMD_LOAD, v, CYL_W'($urandom));
				if (gen_held < STORE_DEPTH) begin
					loaded.push_back(v);
					gen_held++;
				end
				counted++;
			end else begin
				if ($urandom_range(3) == 0)
					v = loaded[$urandom_range(loaded.size() - 1)];
				else
					v = pick_cyl();
				push_req(CMD_RUN, CYL_W'($urandom), v);
				counted++;
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (request_queue.size() != 0 || s_tvalid)
			@(posedge clk);
		while (expected_service.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
